// ===== design/mvt_pkg.sv =====
// Shared types and constants for the 4x4 matrix-vector transform.
// Used by the lane, merge and top-level modules; no dependencies.
package mvt_pkg;

  localparam int NUM_ROWS  = 4;
  localparam int NUM_COLS  = 4;
  localparam int COEF_W    = 16;
  localparam int FRAC_BITS = 12;
  localparam int DATA_W    = 32;
  localparam int COL_W     = NUM_ROWS * COEF_W;
  localparam int PROD_W    = COEF_W + DATA_W;
  localparam int PAIR_W    = PROD_W + 1;
  localparam int SUM_W     = PROD_W + 2;
  localparam int RND_W     = SUM_W - FRAC_BITS;
  localparam int CFG_IDX_W = 3;

  localparam logic [SUM_W-1:0] ROUND_BIAS = SUM_W'(1) << (FRAC_BITS - 1);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_COL1 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COL2 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COL3 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COL4 = 3'd3;

  // Reset values form the identity matrix
  localparam logic [COL_W-1:0] COL1_RESET = 64'h0000_0000_0000_1000;
  localparam logic [COL_W-1:0] COL2_RESET = 64'h0000_0000_1000_0000;
  localparam logic [COL_W-1:0] COL3_RESET = 64'h0000_1000_0000_0000;
  localparam logic [COL_W-1:0] COL4_RESET = 64'h1000_0000_0000_0000;

  localparam logic signed [DATA_W-1:0] OUT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] OUT_MIN = 32'sh8000_0000;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [PAIR_W-1:0] pair_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  typedef coef_t [NUM_COLS-1:0] coef_row_t;
  typedef data_t [NUM_COLS-1:0] vec_t;

  // Rounded dot product handed from a lane to the merge stage
  typedef struct packed {
    logic signed [RND_W-1:0] value;
  } lane_out_t;

endpackage

// ===== design/matrix_vector_transform_4x4.sv =====
// Top level of the 4x4 matrix-vector transform: column registers, four row
// lanes and the merge stage. Depends on mvt_pkg, mvt_lane and mvt_merge.
//
// Usage:
//   Configuration: write a 64-bit matrix column with cfg_valid/cfg_ready,
//   cfg_index 0..3 selecting column 1..4 (row 1 in bits 15:0). Other indexes
//   are ignored. cfg_ready is always high. Write only while no transaction
//   is in flight.
//   Input: a vector (in_x..in_w, signed Q16.16) is taken at a rising edge
//   with start high and busy low. busy is high while rst is held and in the
//   first cycle after it.
//   Output: done strobes for one cycle with out_x..out_w and saturated; the
//   receiver cannot stall, so results are never held.
//   Pipeline: an accepted vector passes the products, pair sums, rounded sum
//   and clip/merge register stages; done is raised together with the results.
//   Throughput: one vector per cycle while busy is low; every stage is a plain register stage.
//   Reset: the matrix returns to identity and all in-flight transactions are
//   dropped.
module matrix_vector_transform_4x4
  import mvt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic signed [31:0]   in_x,
  input  logic signed [31:0]   in_y,
  input  logic signed [31:0]   in_z,
  input  logic signed [31:0]   in_w,
  output logic                 done,
  output logic signed [31:0]   out_x,
  output logic signed [31:0]   out_y,
  output logic signed [31:0]   out_z,
  output logic signed [31:0]   out_w,
  output logic                 saturated,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COL_W-1:0]     cfg_data
);

  logic [COL_W-1:0] col [NUM_COLS];
  logic             accept;
  logic [2:0]       vld;
  vec_t             vec;
  lane_out_t        lane_res [NUM_ROWS];
  data_t            out_val  [NUM_ROWS];

  assign cfg_ready = 1'b1;
  assign accept    = start & ~busy;
  assign vec       = {in_w, in_z, in_y, in_x};

  always_ff @(posedge clk) begin
    busy <= rst;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col[0] <= COL1_RESET;
      col[1] <= COL2_RESET;
      col[2] <= COL3_RESET;
      col[3] <= COL4_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_COL1: col[0] <= cfg_data;
        CFG_COL2: col[1] <= cfg_data;
        CFG_COL3: col[2] <= cfg_data;
        CFG_COL4: col[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Track transactions through the three lane register stages
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[1:0], accept};
    end
  end

  for (genvar r = 0; r < NUM_ROWS; r++) begin : g_lane
    coef_row_t row_coef;

    for (genvar c = 0; c < NUM_COLS; c++) begin : g_coef
      assign row_coef[c] = col[c][r*COEF_W +: COEF_W];
    end

    mvt_lane u_lane (
      .clk    (clk),
      .coef   (row_coef),
      .vec    (vec),
      .result (lane_res[r])
    );
  end

  mvt_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .valid     (vld[2]),
    .lane_res  (lane_res),
    .out_val   (out_val),
    .saturated (saturated),
    .done      (done)
  );

  assign out_x = out_val[0];
  assign out_y = out_val[1];
  assign out_z = out_val[2];
  assign out_w = out_val[3];

`ifndef NO_ASSERTIONS
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##4 done)
    else $error("accepted transaction did not complete after four cycles");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 4))
    else $error("done without a matching accepted transaction");

  a_sat_clipped: assert property (@(posedge clk) disable iff (rst)
    (done && saturated) |-> (out_x == OUT_MAX || out_x == OUT_MIN ||
                             out_y == OUT_MAX || out_y == OUT_MIN ||
                             out_z == OUT_MAX || out_z == OUT_MIN ||
                             out_w == OUT_MAX || out_w == OUT_MIN))
    else $error("saturated flag without a clipped component");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> (busy && !done))
    else $error("block not quiet in the cycle after reset");
`endif

endmodule

// ===== design/mvt_lane.sv =====
// One row lane: four coefficient-by-component products, adder tree and rounding.
// Depends on mvt_pkg.
module mvt_lane
  import mvt_pkg::*;
(
  input  logic      clk,
  input  coef_row_t coef,
  input  vec_t      vec,
  output lane_out_t result
);

  prod_t prod [NUM_COLS];
  pair_t pair [2];
  sum_t  biased;

  always_ff @(posedge clk) begin
    for (int c = 0; c < NUM_COLS; c++) begin
      prod[c] <= coef[c] * vec[c];
    end
  end

  always_ff @(posedge clk) begin
    pair[0] <= {prod[0][PROD_W-1], prod[0]} + {prod[1][PROD_W-1], prod[1]};
    pair[1] <= {prod[2][PROD_W-1], prod[2]} + {prod[3][PROD_W-1], prod[3]};
  end

  // Add the half-LSB bias here; the lane output drops the fraction bits, so the merge stage only clips
  always_ff @(posedge clk) begin
    biased <= {pair[0][PAIR_W-1], pair[0]} + {pair[1][PAIR_W-1], pair[1]} + ROUND_BIAS;
  end

  assign result.value = biased[SUM_W-1:FRAC_BITS];

endmodule

// ===== design/mvt_merge.sv =====
// Merge stage: clips each lane result to 32 bits and combines the clip flags.
// Depends on mvt_pkg.
module mvt_merge
  import mvt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      valid,
  input  lane_out_t lane_res [NUM_ROWS],
  output data_t     out_val [NUM_ROWS],
  output logic      saturated,
  output logic      done
);

  data_t clip     [NUM_ROWS];
  logic  clip_hit [NUM_ROWS];
  logic  any_hit;

  always_comb begin
    any_hit = 1'b0;
    for (int r = 0; r < NUM_ROWS; r++) begin
      if (lane_res[r].value > RND_W'(OUT_MAX)) begin
        clip[r]     = OUT_MAX;
        clip_hit[r] = 1'b1;
      end else if (lane_res[r].value < RND_W'(OUT_MIN)) begin
        clip[r]     = OUT_MIN;
        clip_hit[r] = 1'b1;
      end else begin
        clip[r]     = lane_res[r].value[DATA_W-1:0];
        clip_hit[r] = 1'b0;
      end
      any_hit = any_hit | clip_hit[r];
    end
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      out_val[r] <= clip[r];
    end
    saturated <= any_hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= valid;
    end
  end

endmodule
